@@ rtl/core/dfdx_pkg.sv @@
// shared types and constants for the delimited frame deframer
// no dependencies; imported by the parser, the emitter and the top level
`timescale 1ns / 1ps

package dfdx_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CHAR  = 2'd0,
    REG_END_CHAR    = 2'd1,
    REG_PAYLOAD_LEN = 2'd2
  } cfg_reg_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_NO_END  = 2'd2,
    ST_ABORT   = 2'd3
  } status_t;

  // reset values of the configuration registers
  localparam logic [BYTE_W-1:0] START_CHAR_RST  = 8'h2A;
  localparam logic [BYTE_W-1:0] END_CHAR_RST    = 8'h23;
  localparam logic [LEN_W-1:0]  PAYLOAD_LEN_RST = 6'd32;

  // frame outcome handed from parser to emitter
  typedef struct packed {
    logic             run;
    status_t          status;
    logic [LEN_W-1:0] len;
  } frame_ev_t;

  // one result beat
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    status_t           status;
  } out_beat_t;

endpackage

@@ rtl/core/dfdx_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module dfdx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/dfdx_parser.sv @@
// frame parser: hunts for the start character, tracks position and checksum,
// writes payload into the two-bank store; uses dfdx_pkg
`timescale 1ns / 1ps

module dfdx_parser
  import dfdx_pkg::*;
#(
  parameter int PAYLOAD_MAX = 32,
  parameter int IDX_W       = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rx_valid,
  output logic                   rx_ready,
  input  logic [BYTE_W-1:0]      rx_byte,
  input  logic [BYTE_W-1:0]      start_char,
  input  logic [BYTE_W-1:0]      end_char,
  input  logic [LEN_W-1:0]       payload_len,
  output logic                   ev_valid,
  output frame_ev_t              ev,
  input  logic                   ev_take,
  input  logic                   run_active,
  output logic [PAYLOAD_MAX-1:0] snap,
  output logic                   ram_we,
  output logic [IDX_W:0]         ram_waddr,
  output logic [BYTE_W-1:0]      ram_wdata
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PAYLOAD_MAX);

  logic                   in_frame;
  logic [LEN_W-1:0]       pos;
  logic [BYTE_W-1:0]      run_xor;
  logic [BYTE_W-1:0]      check;
  logic [PAYLOAD_MAX-1:0] latest;

  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] idx;
  logic             is_start;
  logic             will_write;
  logic             will_event;
  logic             close_ok;
  logic             ev_free;
  logic             rd_busy;
  logic             wr_bank;
  logic             conflict;
  logic             accept;

  always_comb begin
    if (payload_len == '0) begin
      len = LEN_W'(1);
    end else if (payload_len > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = payload_len;
    end
  end

  assign idx        = pos[IDX_W-1:0];
  assign is_start   = (rx_byte == start_char);
  assign will_write = in_frame && !is_start && (pos < len);
  assign will_event = in_frame && (is_start || (pos > len));
  assign close_ok   = in_frame && !is_start && (pos > len) && (rx_byte == end_char) &&
                      (check == run_xor);
  assign ev_free    = !ev_valid || ev_take;
  // store still owed to a run, pending or being read out
  assign rd_busy    = run_active || (ev_valid && ev.run);
  // each entry alternates banks, so the previous frame's copy stays intact
  assign wr_bank    = ~latest[idx];
  assign conflict   = will_write && rd_busy && (wr_bank == snap[idx]);

  assign rx_ready = !(will_event && !ev_free) && !conflict && !(close_ok && rd_busy);
  assign accept   = rx_valid && rx_ready;

  assign ram_we    = accept && will_write;
  assign ram_waddr = {idx, wr_bank};
  assign ram_wdata = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      pos      <= '0;
      run_xor  <= '0;
      check    <= '0;
      latest   <= '0;
      snap     <= '0;
      ev_valid <= 1'b0;
    end else begin
      // every accepted abort or closing byte raises an event
      if (accept && will_event) begin
        ev_valid <= 1'b1;
      end else if (ev_take) begin
        ev_valid <= 1'b0;
      end
      if (accept) begin
        if (!in_frame || is_start) begin
          if (is_start) begin
            in_frame <= 1'b1;
            pos      <= '0;
            run_xor  <= '0;
            check    <= '0;
          end
          if (in_frame) begin
            ev <= '{run: 1'b0, status: ST_ABORT, len: '0};
          end
        end else if (pos < len) begin
          latest[idx] <= wr_bank;
          run_xor     <= run_xor ^ rx_byte;
          pos         <= pos + LEN_W'(1);
        end else if (pos == len) begin
          check <= rx_byte;
          pos   <= pos + LEN_W'(1);
        end else begin
          in_frame <= 1'b0;
          pos      <= '0;
          if (rx_byte != end_char) begin
            ev <= '{run: 1'b0, status: ST_NO_END, len: '0};
          end else if (check != run_xor) begin
            ev <= '{run: 1'b0, status: ST_BAD_SUM, len: '0};
          end else begin
            ev   <= '{run: 1'b1, status: ST_OK, len: len};
            snap <= latest;
          end
        end
      end
    end
  end

  a_hunt_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> pos == '0)
    else $error("position not cleared while hunting");

  a_run_len_range: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev.run |-> (ev.len != '0) && (ev.len <= LEN_MAX))
    else $error("run length out of range");

  a_snap_held: assert property (@(posedge clk) disable iff (rst)
    rd_busy |=> $stable(snap))
    else $error("bank snapshot changed while a run still needs it");

endmodule

@@ rtl/core/dfdx_emitter.sv @@
// result emitter: reads a good frame out of the store as a run of beats and
// queues status beats, through a two-entry output buffer; uses dfdx_pkg
`timescale 1ns / 1ps

module dfdx_emitter
  import dfdx_pkg::*;
#(
  parameter int PAYLOAD_MAX = 32,
  parameter int IDX_W       = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ev_valid,
  input  frame_ev_t              ev,
  output logic                   ev_take,
  output logic                   run_active,
  input  logic [PAYLOAD_MAX-1:0] snap,
  output logic                   ram_re,
  output logic [IDX_W:0]         ram_raddr,
  input  logic [BYTE_W-1:0]      ram_rdata,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BYTE_W-1:0]      data_byte,
  output logic                   last,
  output logic [1:0]             status
);

  logic [LEN_W-1:0] rd_k;
  logic [LEN_W-1:0] rd_len;
  logic             inflight;
  logic             inflight_last;

  out_beat_t fifo_mem [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] occ;

  logic       pop;
  logic       push;
  logic       status_push;
  logic       space_ok;
  logic       issue;
  logic       last_k;
  logic [2:0] credit;
  out_beat_t  push_beat;
  out_beat_t  head;
  logic [IDX_W-1:0] k_idx;

  assign head      = fifo_mem[rd_ptr];
  assign out_valid = (occ != 2'd0);
  assign data_byte = head.data;
  assign last      = head.last;
  assign status    = head.status;

  assign pop      = out_valid && out_ready;
  assign space_ok = (occ < 2'd2) || pop;
  // reads in flight count against buffer space
  assign credit   = {1'b0, occ} + {2'b0, inflight};
  assign issue    = run_active && (credit < (3'd2 + {2'b0, pop}));
  assign last_k   = (rd_k == (rd_len - LEN_W'(1)));
  assign k_idx    = rd_k[IDX_W-1:0];

  assign ram_re    = issue;
  assign ram_raddr = {k_idx, snap[k_idx]};

  // an event waits until every earlier run beat is in the buffer
  assign ev_take     = ev_valid && !run_active && !inflight && (ev.run || space_ok);
  assign status_push = ev_take && !ev.run;
  assign push        = inflight || status_push;

  always_comb begin
    if (inflight) begin
      push_beat = '{data: ram_rdata, last: inflight_last, status: ST_OK};
    end else begin
      push_beat = '{data: '0, last: 1'b1, status: ev.status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active    <= 1'b0;
      rd_k          <= '0;
      rd_len        <= '0;
      inflight      <= 1'b0;
      inflight_last <= 1'b0;
      wr_ptr        <= 1'b0;
      rd_ptr        <= 1'b0;
      occ           <= 2'd0;
    end else begin
      inflight      <= issue;
      inflight_last <= last_k;
      if (ev_take && ev.run) begin
        run_active <= 1'b1;
        rd_k       <= '0;
        rd_len     <= ev.len;
      end else if (issue) begin
        rd_k <= rd_k + LEN_W'(1);
        if (last_k) begin
          run_active <= 1'b0;
        end
      end
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      occ <= occ + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_beat;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ != 2'd3)
    else $error("output buffer overfilled");

  a_run_index: assert property (@(posedge clk) disable iff (rst)
    run_active |-> rd_k < rd_len)
    else $error("run read index past run length");

  a_mid_run_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !head.last |-> head.status == ST_OK)
    else $error("non-final beat carries an error status");

endmodule

@@ rtl/core/delimited_frame_deframer_xor_top.sv @@
// top level of the delimited frame deframer with xor checksum
// holds the configuration registers; uses dfdx_pkg, dfdx_parser, dfdx_emitter, dfdx_ram
`timescale 1ns / 1ps

// Receives one byte per beat on rx and can take a new byte every clock cycle
// while rx_ready is high. While hunting, every byte but start_char is
// dropped. A frame is start_char, payload_len payload bytes, one checksum
// byte (xor of the payload) and end_char. A good frame comes out as a run of
// payload_len beats, ok status, last set on the final one; a bad end
// character (checked first), a bad checksum or a start_char inside a frame
// gives one status beat with data_byte zero and last set, and a start_char
// inside a frame opens a new frame at once. payload_len of 0 counts as 1,
// above PAYLOAD_MAX as PAYLOAD_MAX. Results leave through a two-entry
// buffer, so input keeps flowing while a beat waits. A status beat reaches
// out_valid through the event register, then the buffer; the first beat of
// a good run passes the event register, the store read start and the
// registered store read, then one beat follows per cycle while out_ready
// stays high. A status beat queued behind a run waits until the run's last
// beat is in the buffer. The store has two banks per payload position, one
// for the frame being read out and one for the frame being collected.
// rx_ready drops when a payload byte would land in the bank that a pending
// or active run still has to read (back-pressure on out, or an aborted
// frame followed by a new one before the run is out), when a good frame
// closes while the previous run is still owed, or when a frame outcome
// finds the previous one still queued.
// Configuration is written through cfg_we / cfg_index / cfg_data, index 0
// start_char, 1 end_char, 2 payload_len; other indexes are ignored.
module delimited_frame_deframer_xor_top
  import dfdx_pkg::*;
#(
  parameter int PAYLOAD_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // receive channel
  input  logic                 rx_valid,
  output logic                 rx_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    data_byte,
  output logic                 last,
  output logic [1:0]           status,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  // store index width; two banks sit in the low address bit
  localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int DEPTH = 2 ** (IDX_W + 1);

  // configuration registers
  logic [BYTE_W-1:0] start_char;
  logic [BYTE_W-1:0] end_char;
  logic [LEN_W-1:0]  payload_len;

  // parser to emitter
  logic                   ev_valid;
  frame_ev_t              ev;
  logic                   ev_take;
  logic                   run_active;
  logic [PAYLOAD_MAX-1:0] snap;

  // payload store ports
  logic              ram_we;
  logic [IDX_W:0]    ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W:0]    ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char  <= START_CHAR_RST;
      end_char    <= END_CHAR_RST;
      payload_len <= PAYLOAD_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_CHAR:  start_char  <= cfg_data;
        REG_END_CHAR:    end_char    <= cfg_data;
        REG_PAYLOAD_LEN: payload_len <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // byte-by-byte frame tracking and payload writes
  dfdx_parser #(
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .IDX_W       (IDX_W)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_ready    (rx_ready),
    .rx_byte     (rx_byte),
    .start_char  (start_char),
    .end_char    (end_char),
    .payload_len (payload_len),
    .ev_valid    (ev_valid),
    .ev          (ev),
    .ev_take     (ev_take),
    .run_active  (run_active),
    .snap        (snap),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  // two-bank payload store, one entry per bank for each payload position
  dfdx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // run read-out, status beats and output buffer
  dfdx_emitter #(
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .IDX_W       (IDX_W)
  ) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .ev_valid   (ev_valid),
    .ev         (ev),
    .ev_take    (ev_take),
    .run_active (run_active),
    .snap       (snap),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .last       (last),
    .status     (status)
  );

endmodule

@@ sim/delimited_frame_deframer_xor_top_test.sv @@
// self-checking testbench for the delimited frame deframer with xor checksum
// drives rx beats and config writes, predicts result beats and checks them field by field
// depends on dfdx_pkg and delimited_frame_deframer_xor_top
`timescale 1ns / 1ps

module delimited_frame_deframer_xor_top_test
  import dfdx_pkg::*;
;

  localparam int PAYLOAD_MAX = 32;
  localparam int HOLD_CYCLES = 400;    // long output stall for the back-pressure test
  localparam int DRAIN_CYCLES = 10;    // parser stage plus two-entry output buffer, with margin

  // every input driven to a known value from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 rx_valid = 1'b0;
  logic                 rx_ready;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    data_byte;
  logic                 last;
  logic [1:0]           status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_CHAR;
  logic [BYTE_W-1:0]    cfg_data = '0;

  delimited_frame_deframer_xor_top #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_byte  (rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data_byte(data_byte),
    .last     (last),
    .status   (status),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: own copy of the configuration and the frame parser state
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] cfg_start = START_CHAR_RST;
  logic [BYTE_W-1:0] cfg_end   = END_CHAR_RST;
  logic [LEN_W-1:0]  cfg_len   = PAYLOAD_LEN_RST;

  bit                frame_open = 1'b0;   // 0 while hunting for the start character
  int                pos = 0;             // position within the frame after the start
  logic [BYTE_W-1:0] run_xor = '0;        // xor of payload bytes so far
  logic [BYTE_W-1:0] rx_check = '0;       // checksum byte as received
  logic [BYTE_W-1:0] payload_store [PAYLOAD_MAX];

  out_beat_t         expected_beats [$];  // result beats still owed by the block
  out_beat_t         want;
  int                errors = 0;
  int                items_sent = 0;

  // stimulus shaping, written only by the test process
  int                rx_idle_pct = 0;
  int                out_idle_pct = 0;
  bit                hold_req = 1'b0;     // toggled to ask the receiver for a long stall

  logic [BYTE_W-1:0] body [$];            // payload of the frame being built

  // a length of zero counts as one, anything above the store size as the store size
  function automatic int effective_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > PAYLOAD_MAX) return PAYLOAD_MAX;
    return int'(cfg_len);
  endfunction

  function automatic void open_frame();
    frame_open = 1'b1;
    pos = 0;
    run_xor = '0;
    rx_check = '0;
  endfunction

  // status beats carry zero data and always close their run
  function automatic void push_status(input status_t code);
    out_beat_t beat;
    beat.data = '0;
    beat.last = 1'b1;
    beat.status = code;
    expected_beats.push_back(beat);
  endfunction

  // advance the parser by one accepted rx beat and queue the beats it causes
  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    int len;
    out_beat_t beat;
    len = effective_len();
    if (!frame_open) begin
      if (b == cfg_start) open_frame();
    end else if (b == cfg_start) begin
      // a start character anywhere in a frame aborts it and opens the next one
      open_frame();
      push_status(ST_ABORT);
    end else if (pos < len) begin
      payload_store[pos] = b;
      run_xor = run_xor ^ b;
      pos++;
    end else if (pos == len) begin
      rx_check = b;
      pos++;
    end else begin
      // closing byte: end character first, checksum only if that is right
      frame_open = 1'b0;
      pos = 0;
      if (b != cfg_end) push_status(ST_NO_END);
      else if (rx_check != run_xor) push_status(ST_BAD_SUM);
      else begin
        for (int k = 0; k < len; k++) begin
          beat.data = payload_store[k];
          beat.last = (k == len - 1);
          beat.status = ST_OK;
          expected_beats.push_back(beat);
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random ready, with a long hold when asked
  // ---------------------------------------------------------------------------
  bit hold_seen = 1'b0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // every accepted result beat is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: data_byte %0h last %0b status %0d",
               data_byte, last, status);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (data_byte !== want.data) begin
          $error("data_byte expected %0h got %0h", want.data, data_byte);
          errors++;
        end
        if (last !== want.last) begin
          $error("last expected %0b got %0b", want.last, last);
          errors++;
        end
        if (status !== 2'(want.status)) begin
          $error("status expected %0d got %0d", want.status, status);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared stimulus tasks, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // offer one rx beat, with random gaps ahead of it, and hold it until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    deframe_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait for every owed beat, then for the pipeline to empty
  task automatic settle();
    rx_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one write strobe, then a quiet gap with cfg_we low so back-to-back writes stay apart
  task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_START_CHAR:  cfg_start = value;
      REG_END_CHAR:    cfg_end = value;
      REG_PAYLOAD_LEN: cfg_len = value[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // random payload that never holds the start character
  function automatic void fill_random_body(input int n);
    logic [BYTE_W-1:0] b;
    body.delete();
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == cfg_start);
      body.push_back(b);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] body_xor();
    logic [BYTE_W-1:0] x;
    x = '0;
    foreach (body[i]) x = x ^ body[i];
    return x;
  endfunction

  // start, payload, checksum (optionally spoilt) and a closing byte
  task automatic send_frame(input logic [BYTE_W-1:0] sum_flip,
                            input logic [BYTE_W-1:0] closing);
    send_byte(cfg_start);
    foreach (body[i]) send_byte(body[i]);
    send_byte(body_xor() ^ sum_flip);
    send_byte(closing);
  endtask

  // feed a byte that is neither delimiter until the parser hunts again
  task automatic close_open_frame();
    logic [BYTE_W-1:0] filler;
    filler = 8'h00;
    while (filler == cfg_start || filler == cfg_end) filler++;
    while (frame_open) send_byte(filler);
  endtask

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // reset values: '*' opens, '#' closes, full 32 byte payload
  task automatic test_default_frame();
    fill_random_body(effective_len());
    body[0] = 8'h00;
    body[1] = 8'hFF;
    body[2] = cfg_end;          // end character inside the payload is plain data
    send_frame(8'h00, cfg_end);
    settle();
  endtask

  // zero length counts as one, length above the store size is clipped
  task automatic test_length_limits();
    write_reg(REG_PAYLOAD_LEN, 8'd0);
    fill_random_body(effective_len());
    send_frame(8'h00, cfg_end);
    settle();
    write_reg(REG_PAYLOAD_LEN, 8'd63);
    fill_random_body(effective_len());
    send_frame(8'h00, cfg_end);
    settle();
    write_reg(REG_PAYLOAD_LEN, 8'd1);
    body.delete();
    body.push_back(8'hFF);
    send_frame(8'h00, cfg_end);
    settle();
  endtask

  // bad end, bad checksum, both, aborts at each position, noise while hunting
  task automatic test_frame_errors();
    rx_idle_pct = 30;
    out_idle_pct = 76;
    // upper bits of the write data are dropped, leaving a length of three
    write_reg(REG_PAYLOAD_LEN, 8'hC3);
    fill_random_body(effective_len());
    send_frame(8'h00, cfg_end ^ 8'h01);
    send_frame(8'h5A, cfg_end);
    send_frame(8'h01, cfg_end ^ 8'h01);    // end character is judged first
    // bytes while hunting are dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cfg_end);
    // start character inside the payload
    send_byte(cfg_start);
    send_byte(body[0]);
    send_byte(body[1]);
    send_frame(8'h00, cfg_end);
    // start character where the checksum belongs
    send_byte(cfg_start);
    foreach (body[i]) send_byte(body[i]);
    send_frame(8'h00, cfg_end);
    // start character where the closing byte belongs
    send_byte(cfg_start);
    foreach (body[i]) send_byte(body[i]);
    send_byte(body_xor());
    send_frame(8'h00, cfg_end);
    settle();
  endtask

  // same character for both delimiters: every frame aborts at its closing byte
  task automatic test_equal_delimiters();
    write_reg(REG_START_CHAR, 8'h7E);
    write_reg(REG_END_CHAR, 8'h7E);
    write_reg(REG_PAYLOAD_LEN, 8'd2);
    fill_random_body(effective_len());
    send_frame(8'h00, cfg_end);
    send_byte(body[0]);
    send_byte(body[1]);
    send_byte(body_xor());
    send_byte(cfg_end);
    close_open_frame();
    settle();
  endtask

  // length written while a frame is open applies from the next beat on
  task automatic test_length_change_mid_frame();
    write_reg(REG_START_CHAR, START_CHAR_RST);
    write_reg(REG_END_CHAR, END_CHAR_RST);
    // shorter, still inside the payload
    write_reg(REG_PAYLOAD_LEN, 8'd8);
    fill_random_body(5);
    send_byte(cfg_start);
    for (int i = 0; i < 3; i++) send_byte(body[i]);
    settle();
    write_reg(REG_PAYLOAD_LEN, 8'd5);
    for (int i = 3; i < 5; i++) send_byte(body[i]);
    send_byte(body_xor());
    send_byte(cfg_end);
    settle();
    // shorter, landing exactly on the checksum position
    write_reg(REG_PAYLOAD_LEN, 8'd8);
    fill_random_body(4);
    send_byte(cfg_start);
    foreach (body[i]) send_byte(body[i]);
    settle();
    write_reg(REG_PAYLOAD_LEN, 8'd4);
    send_byte(body_xor());
    send_byte(cfg_end);
    settle();
    // shorter, past the checksum: the next beat is the closing byte
    write_reg(REG_PAYLOAD_LEN, 8'd8);
    fill_random_body(6);
    send_byte(cfg_start);
    foreach (body[i]) send_byte(body[i]);
    settle();
    write_reg(REG_PAYLOAD_LEN, 8'd3);
    send_byte(cfg_end);
    settle();
    // longer, from the checksum position on
    write_reg(REG_PAYLOAD_LEN, 8'd3);
    fill_random_body(6);
    send_byte(cfg_start);
    for (int i = 0; i < 3; i++) send_byte(body[i]);
    settle();
    write_reg(REG_PAYLOAD_LEN, 8'd6);
    for (int i = 3; i < 6; i++) send_byte(body[i]);
    send_byte(body_xor());
    send_byte(cfg_end);
    settle();
  endtask

  // output held off for a long stretch while frames keep arriving back to back
  task automatic test_output_backpressure();
    rx_idle_pct = 0;
    out_idle_pct = 0;
    write_reg(REG_PAYLOAD_LEN, 8'd4);
    hold_req <= ~hold_req;
    for (int f = 0; f < 3; f++) begin
      fill_random_body(effective_len());
      send_frame(8'h00, (f == 1) ? (cfg_end ^ 8'h40) : cfg_end);
    end
    settle();
  endtask

  // mostly well-formed frames with random content, the rest broken or noise
  task automatic run_random_phase(input int n_items);
    int first;
    int pick;
    int len;
    int k;
    logic [BYTE_W-1:0] bad;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(0, 99);
      len = effective_len();
      fill_random_body(len);
      if (pick < 65) begin
        send_frame(8'h00, cfg_end);
      end else if (pick < 75) begin
        send_frame(8'($urandom_range(1, 255)), cfg_end);
      end else if (pick < 85) begin
        do bad = 8'($urandom_range(0, 255)); while (bad == cfg_end);
        send_frame(8'h00, bad);
      end else if (pick < 93) begin
        // cut short; later bytes finish it or a start character aborts it
        k = $urandom_range(0, len + 1);
        send_byte(cfg_start);
        for (int i = 0; i < k; i++) send_byte((i < len) ? body[i] : body_xor());
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    close_open_frame();
    settle();
  endtask

  // three settings, each with its own idling pattern
  task automatic test_random_traffic();
    write_reg(REG_START_CHAR, 8'h00);
    write_reg(REG_END_CHAR, 8'hFF);
    write_reg(REG_PAYLOAD_LEN, 8'd1);
    rx_idle_pct = 30;
    out_idle_pct = 76;
    run_random_phase(10);

    write_reg(REG_START_CHAR, 8'hFF);
    write_reg(REG_END_CHAR, 8'h00);
    write_reg(REG_PAYLOAD_LEN, 8'd6);
    rx_idle_pct = 76;
    out_idle_pct = 30;
    run_random_phase(10);

    write_reg(REG_START_CHAR, 8'h5A);
    write_reg(REG_END_CHAR, 8'hA5);
    write_reg(REG_PAYLOAD_LEN, 8'd3);
    rx_idle_pct = 0;
    out_idle_pct = 0;
    run_random_phase(10);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_frame();
    test_length_limits();
    test_frame_errors();
    test_equal_delimiters();
    test_length_change_mid_frame();
    test_output_backpressure();
    test_random_traffic();

    // nothing owed any more; give stray beats a chance to show up
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/dfdx_pkg.sv
rtl/core/dfdx_ram.sv
rtl/core/dfdx_parser.sv
rtl/core/dfdx_emitter.sv
rtl/core/delimited_frame_deframer_xor_top.sv
sim/delimited_frame_deframer_xor_top_test.sv
